// ===== rtl/i2cs_pkg.sv =====
package i2cs_pkg;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_PUSH    = 2'd1;
    localparam logic [1:0] OP_POLL    = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_SEND      = 3'd2;
    localparam logic [2:0] CMD_READ_ACK  = 3'd3;
    localparam logic [2:0] CMD_READ_NACK = 3'd4;
    localparam logic [2:0] CMD_STOP      = 3'd5;
    localparam logic [2:0] CMD_RESET     = 3'd6;

    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RSTART    = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
    localparam logic [7:0] ST_DATW_ACK  = 8'h28;
    localparam logic [7:0] ST_DATW_NACK = 8'h30;
    localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
    localparam logic [7:0] ST_DATR_ACK  = 8'h50;
    localparam logic [7:0] ST_DATR_NACK = 8'h58;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    typedef struct packed {
        logic [1:0] operation;
        logic [6:0] target_addr;
        logic [7:0] write_count;
        logic [7:0] read_count;
        logic [7:0] write_byte;
        logic       engine_done;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
        logic       stop_pending;
    } t_in_word;

    typedef struct packed {
        logic       accepted;
        logic [2:0] command;
        logic [7:0] command_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_valid;
        logic       done_ok;
        logic [7:0] done_read_total;
    } t_out_word;

    typedef struct packed {
        logic [7:0] read_count;
        logic [7:0] write_count;
        logic [6:0] target_addr;
    } t_req;

endpackage

// ===== rtl/i2cs_if.sv =====
interface i2cs_in_if;
    logic                valid;
    logic                ready;
    i2cs_pkg::t_in_word  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cs_out_if;
    logic                valid;
    logic                ready;
    i2cs_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/i2cs_fifo.sv =====
module i2cs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 8,
    parameter int DROPW = 8,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [W-1:0]     i_push_data,
    input  logic [DROPW-1:0] i_drop,
    output logic [W-1:0]     o_head,
    output logic [CW-1:0]    o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW = (CW > DROPW) ? CW : DROPW;
    localparam int SW = CW + 1;

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] r_rd, n_rd, wa;
    logic [CW-1:0] r_count, n_count, k;
    logic          r_load, n_load, push_ok;
    logic [W-1:0]  r_cache, n_cache, r_rdata, head;
    logic [SW-1:0] wsum, rsum;

    always_comb begin
        k       = (MW'(i_drop) > MW'(r_count)) ? r_count : CW'(i_drop);
        push_ok = i_push && (r_count < CW'(DEPTH));
        wsum    = SW'(r_rd) + SW'(r_count);
        wa      = (wsum >= SW'(DEPTH)) ? AW'(wsum - SW'(DEPTH)) : AW'(wsum);
        rsum    = SW'(r_rd) + SW'(k);
        n_rd    = (rsum >= SW'(DEPTH)) ? AW'(rsum - SW'(DEPTH)) : AW'(rsum);
        n_count = r_count + CW'(push_ok) - k;
        head    = r_load ? r_rdata : r_cache;
        n_cache = head;
        if (push_ok && (r_count == '0)) begin
            n_cache = i_push_data;
        end
        // refetch the head word whenever the read side advances and entries remain
        n_load  = (k != '0) && (n_count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            mem[wa] <= i_push_data;
        end
        r_rdata <= mem[n_rd];
        r_cache <= n_cache;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_count <= '0;
            r_load  <= 1'b0;
        end else begin
            r_rd    <= n_rd;
            r_count <= n_count;
            r_load  <= n_load;
        end
    end

    assign o_head  = head;
    assign o_count = r_count;
endmodule

// ===== rtl/i2c_master_transaction_sequencer.sv =====
// I2C master transaction sequencer. Each input word is an enqueue, a write
// data push, an engine poll or a one-millisecond tick; every accepted word
// yields exactly one result word, held in an output register and shown the
// cycle after acceptance. One word is taken per clock: ready is high while
// the output register is empty or being taken this cycle, so a steady
// stream runs at one word per cycle, limited only by that register. The
// request queue and the write data FIFO live in synchronous memories; each
// keeps its head word in a show-ahead register that is refetched from the
// memory as the head advances, so back-to-back pops are served from the
// read data directly. No clearing pass is needed after reset.
// timeout_ms is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while the block is idle (not enforced); it resets to 5000.
module i2c_master_transaction_sequencer #(
    parameter int QUEUE_DEPTH      = 8,
    parameter int WRITE_FIFO_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    i2cs_in_if.sink     i_in,
    i2cs_out_if.source  o_out
);
    import i2cs_pkg::*;

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int FCW = $clog2(WRITE_FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_IDLE, PH_RESET, PH_START_DO, PH_START_TX, PH_ADDR,
        PH_WRITE_FIRST, PH_WRITE, PH_RSTART_DO, PH_RSTART_TX,
        PH_READ_FIRST, PH_READ, PH_STOP_DO, PH_STOP_TX, PH_FAILED
    } t_phase;

    t_phase    r_phase, n_phase;
    logic [15:0] r_timeout;
    logic [15:0] r_elapsed, n_elapsed;
    logic [6:0]  r_addr, n_addr;
    logic [7:0]  r_wl, n_wl, r_rl, n_rl, r_rdn, n_rdn;
    logic        r_out_valid;
    t_out_word   r_out, n_out;

    t_in_word    w;
    logic        in_fire, busy, tmo, fin, fin_ok, start, q_push, f_push;
    t_req        start_req, q_head, q_new;
    logic [QCW-1:0] q_count;
    logic [FCW-1:0] f_count;
    logic [7:0]  f_head, f_drop;
    logic        q_drop;

    assign w       = i_in.data;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire = i_in.valid && i_in.ready;
    assign busy    = !w.engine_done;
    assign tmo     = r_elapsed >= r_timeout;
    assign q_new   = '{read_count: w.read_count, write_count: w.write_count,
                       target_addr: w.target_addr};

    i2cs_fifo #(.W($bits(t_req)), .DEPTH(QUEUE_DEPTH), .DROPW(1)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_push_data(q_new),
        .i_drop(q_drop), .o_head(q_head), .o_count(q_count)
    );

    i2cs_fifo #(.W(8), .DEPTH(WRITE_FIFO_DEPTH), .DROPW(8)) u_wfifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_push),
        .i_push_data(w.write_byte), .i_drop(f_drop), .o_head(f_head),
        .o_count(f_count)
    );

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_addr    = r_addr;
        n_wl      = r_wl;
        n_rl      = r_rl;
        n_rdn     = r_rdn;
        n_out     = '0;
        fin       = 1'b0;
        fin_ok    = 1'b0;
        start     = 1'b0;
        start_req = q_head;
        q_push    = 1'b0;
        f_push    = 1'b0;
        f_drop    = '0;
        q_drop    = 1'b0;
        if (in_fire) begin
            unique case (w.operation)
                OP_ENQUEUE: begin
                    // reject empty requests and a full queue
                    if (!((w.write_count == '0) && (w.read_count == '0))
                            && (q_count < QCW'(QUEUE_DEPTH))) begin
                        q_push         = 1'b1;
                        n_out.accepted = 1'b1;
                        if (r_phase == PH_IDLE) begin
                            start     = 1'b1;
                            start_req = q_new;
                        end
                    end
                end
                OP_PUSH: begin
                    if (f_count < FCW'(WRITE_FIFO_DEPTH)) begin
                        f_push         = 1'b1;
                        n_out.accepted = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (r_elapsed != 16'hFFFF) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                end
                OP_POLL: begin
                    unique case (r_phase)
                        PH_RESET, PH_STOP_TX: begin
                            if (w.stop_pending) begin
                                // stop stuck past the deadline: reset engine
                                if (r_phase == PH_STOP_TX && tmo) begin
                                    n_out.command = CMD_RESET;
                                    n_phase       = PH_RESET;
                                end
                            end else if (q_count != '0) begin
                                start = 1'b1;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_START_DO, PH_RSTART_DO: begin
                            n_out.command = CMD_START;
                            n_phase = (r_phase == PH_START_DO) ? PH_START_TX
                                                               : PH_RSTART_TX;
                        end
                        PH_START_TX, PH_RSTART_TX: begin
                            if (busy) begin
                                fin = tmo;
                            end else if (w.bus_status != ST_START
                                    && w.bus_status != ST_RSTART) begin
                                fin = 1'b1;
                            end else begin
                                n_out.command      = CMD_SEND;
                                n_out.command_byte = {r_addr, r_wl == '0};
                                n_phase            = PH_ADDR;
                            end
                        end
                        PH_ADDR: begin
                            if (busy) begin
                                fin = tmo;
                            end else if ((w.bus_status != ST_SLAW_ACK || r_wl == '0)
                                    && w.bus_status != ST_SLAR_ACK) begin
                                fin = 1'b1;
                            end else begin
                                n_phase = (w.bus_status == ST_SLAW_ACK)
                                        ? PH_WRITE_FIRST : PH_READ_FIRST;
                            end
                        end
                        PH_WRITE_FIRST, PH_WRITE: begin
                            if (r_phase == PH_WRITE && busy) begin
                                fin = tmo;
                            end else if (r_phase == PH_WRITE
                                    && w.bus_status != ST_DATW_ACK
                                    && (w.bus_status != ST_DATW_NACK || r_wl != '0)) begin
                                fin = 1'b1;
                            end else if (r_wl == '0) begin
                                if (r_rl != '0) begin
                                    n_phase = PH_RSTART_DO;
                                end else begin
                                    fin    = 1'b1;
                                    fin_ok = 1'b1;
                                end
                            end else begin
                                // an empty FIFO sends a zero byte
                                n_out.command      = CMD_SEND;
                                n_out.command_byte = (f_count != '0) ? f_head : 8'd0;
                                f_drop             = 8'd1;
                                n_wl               = r_wl - 8'd1;
                                n_phase            = PH_WRITE;
                            end
                        end
                        PH_READ_FIRST, PH_READ: begin
                            if (r_phase == PH_READ && busy) begin
                                fin = tmo;
                            end else if (r_phase == PH_READ
                                    && w.bus_status != ST_DATR_ACK
                                    && w.bus_status != ST_DATR_NACK) begin
                                fin = 1'b1;
                            end else begin
                                if (r_phase == PH_READ) begin
                                    n_out.read_valid = 1'b1;
                                    n_out.read_byte  = w.rx_byte;
                                    if (r_rl != '0) begin
                                        n_rl = r_rl - 8'd1;
                                    end
                                    n_rdn = r_rdn + 8'd1;
                                end
                                if (n_rl != '0) begin
                                    n_out.command = (n_rl > 8'd1) ? CMD_READ_ACK
                                                                  : CMD_READ_NACK;
                                    n_phase       = PH_READ;
                                end else begin
                                    fin    = 1'b1;
                                    fin_ok = 1'b1;
                                end
                            end
                        end
                        PH_STOP_DO: begin
                            n_out.command = CMD_STOP;
                            n_phase       = PH_STOP_TX;
                        end
                        PH_FAILED: begin
                            n_out.command = CMD_RESET;
                            n_phase       = PH_RESET;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        if (fin) begin
            // report completion, drop unsent write bytes, retire the head
            n_out.done_valid      = 1'b1;
            n_out.done_ok         = fin_ok;
            n_out.done_read_total = n_rdn;
            f_drop                = r_wl;
            n_wl                  = '0;
            q_drop                = q_count != '0;
            n_phase               = fin_ok ? PH_STOP_DO : PH_FAILED;
        end
        if (start) begin
            n_phase   = PH_START_DO;
            n_elapsed = '0;
            n_addr    = start_req.target_addr;
            n_wl      = start_req.write_count;
            n_rl      = start_req.read_count;
            n_rdn     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_timeout   <= TIMEOUT_RESET;
            r_elapsed   <= '0;
            r_wl        <= '0;
            r_rl        <= '0;
            r_rdn       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_wl      <= n_wl;
            r_rl      <= n_rl;
            r_rdn     <= n_rdn;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

// ===== rtl/i2cs_checker.sv =====
module i2cs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input i2cs_pkg::t_out_word i_out_data
);
    import i2cs_pkg::*;

    // every accepted word yields a result word next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("no result after accepted word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.done_valid) |->
            (i_out_data.command == CMD_NONE && !i_out_data.accepted))
        else $error("completion with a command");

    a_read_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.read_valid) |->
            (i_out_data.command != CMD_START && i_out_data.command != CMD_SEND
             && !i_out_data.accepted))
        else $error("read byte with a bad command");
endmodule

bind i2c_master_transaction_sequencer i2cs_checker u_i2cs_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_data(o_out.data)
);
